@@ hw/rtl/fixed_frame_receiver_defines.svh @@
// Assertion macros shared by the frame receiver RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef FIXED_FRAME_RECEIVER_DEFINES_SVH
`define FIXED_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define FFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define FFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/ffr_pkg.sv @@
// Constants and types for the fixed-length frame receiver.
// No dependencies.
package ffr_pkg;

    localparam int unsigned PAY_LEN    = 12;
    localparam int unsigned WORD_COUNT = PAY_LEN / 2;
    localparam int unsigned PAY_IDX_W  = $clog2(PAY_LEN);

    localparam logic [7:0] HDR0 = 8'h7F;
    localparam logic [7:0] HDR1 = 8'hFE;
    localparam logic [7:0] TRL0 = 8'h7F;
    localparam logic [7:0] TRL1 = 8'hFF;

    localparam logic [3:0] POS_HDR0      = 4'd0;
    localparam logic [3:0] POS_HDR1      = 4'd1;
    localparam logic [3:0] POS_PAY_FIRST = 4'd2;
    localparam logic [3:0] POS_PAY_LAST  = 4'd13;
    localparam logic [3:0] POS_TRL0      = 4'd14;
    localparam logic [3:0] POS_TRL1      = 4'd15;

    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_GOOD = 2'd1,
        ST_ERR  = 2'd2
    } t_status;

    typedef struct packed {
        t_status                        status;
        logic [WORD_COUNT-1:0][15:0]    words;
    } t_result;

endpackage

@@ hw/rtl/fixed_frame_receiver.sv @@
// Fixed 16-byte frame receiver: header/trailer check and payload word latch.
// Depends on ffr_pkg and fixed_frame_receiver_defines.svh.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+------------------------------------------------
//  byte in | i_valid | o_stall | i_rx_data
//  result  | o_valid | i_stall | o_frame_status, o_word_{pwm,enc,spd}_{left,right}
//
// One byte is taken per cycle while o_stall is low; its result is registered
// into the output register, or into the skid register when the output is held.
// Frame state advances at the input transfer.
// A skid register behind the output register takes one more transfer after
// i_stall rises, so o_stall comes straight from the skid register; no byte is
// taken until the skid has drained into the output register.
// Reset is synchronous, active low: position, held words and valids clear.
`include "fixed_frame_receiver_defines.svh"

module fixed_frame_receiver
    import ffr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_frame_status,
    output logic [15:0] o_word_pwm_left,
    output logic [15:0] o_word_pwm_right,
    output logic [15:0] o_word_enc_left,
    output logic [15:0] o_word_enc_right,
    output logic [15:0] o_word_spd_left,
    output logic [15:0] o_word_spd_right
);

    // Frame state
    logic [3:0]                  r_pos;
    logic [3:0]                  n_pos;
    logic [PAY_LEN-1:0][7:0]     r_pay;
    logic [WORD_COUNT-1:0][15:0] r_held;
    logic [WORD_COUNT-1:0][15:0] n_held;

    // Output buffer
    t_result r_out;
    t_result r_skid;
    t_result n_result;
    logic    r_out_valid;
    logic    r_skid_valid;

    logic in_xfer;
    logic out_xfer;
    logic n_bad;
    logic n_store;
    logic n_good;
    logic [PAY_IDX_W-1:0] pay_idx;

    assign o_stall  = r_skid_valid;
    assign in_xfer  = i_valid && !r_skid_valid;
    assign out_xfer = r_out_valid && !i_stall;
    assign pay_idx  = PAY_IDX_W'(r_pos - POS_PAY_FIRST);

    // Classify the byte against its frame position and build the result.
    always_comb begin
        n_bad   = 1'b0;
        n_store = 1'b0;
        if (r_pos == POS_HDR0) begin
            n_bad = (i_rx_data != HDR0);
        end else if (r_pos == POS_HDR1) begin
            n_bad = (i_rx_data != HDR1);
        end else if (r_pos inside {[POS_PAY_FIRST:POS_PAY_LAST]}) begin
            n_store = 1'b1;
        end else if (r_pos == POS_TRL0) begin
            n_bad = (i_rx_data != TRL0);
        end else begin
            n_bad = (i_rx_data != TRL1);
        end
        n_good = !n_bad && (r_pos == POS_TRL1);

        // Drop back to the start on an error or a finished frame; the bad
        // byte is not retried as a header.
        if (n_bad || n_good) begin
            n_pos = POS_HDR0;
        end else begin
            n_pos = r_pos + 4'd1;
        end

        // Latch the payload as big-endian words on a good frame. The payload
        // store needs no clearing on error: every byte of it is rewritten
        // before the next frame can complete.
        n_held = r_held;
        if (n_good) begin
            for (int k = 0; k < WORD_COUNT; k++) begin
                n_held[k] = {r_pay[2*k], r_pay[2*k+1]};
            end
        end

        n_result.words = n_held;
        if (n_bad) begin
            n_result.status = ST_ERR;
        end else if (n_good) begin
            n_result.status = ST_GOOD;
        end else begin
            n_result.status = ST_BUSY;
        end
    end

    // Frame position and held words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_HDR0;
            r_held <= '0;
        end else if (in_xfer) begin
            r_pos  <= n_pos;
            r_held <= n_held;
        end
    end

    // Payload bytes of the frame in flight
    always_ff @(posedge i_clk) begin
        if (in_xfer && n_store) begin
            r_pay[pay_idx] <= i_rx_data;
        end
    end

    // Output register with skid: refill from the skid first to keep order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_xfer) begin
            r_out_valid  <= r_skid_valid || in_xfer;
            r_skid_valid <= 1'b0;
        end else if (in_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_xfer) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_xfer) begin
                r_out <= n_result;
            end
        end else if (in_xfer) begin
            r_skid <= n_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_frame_status   = r_out.status;
    assign o_word_pwm_left  = r_out.words[0];
    assign o_word_pwm_right = r_out.words[1];
    assign o_word_enc_left  = r_out.words[2];
    assign o_word_enc_right = r_out.words[3];
    assign o_word_spd_left  = r_out.words[4];
    assign o_word_spd_right = r_out.words[5];

    `FFR_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid, "skid full while output empty")
    `FFR_ASSERT_NEXT(a_err_restarts, in_xfer && n_bad, (r_pos == POS_HDR0) && $stable(r_held), "error did not restart frame")
    `FFR_ASSERT_NEXT(a_good_latch, in_xfer && n_good, (r_pos == POS_HDR0) && (r_held[0] == {$past(r_pay[0]), $past(r_pay[1])}), "good frame not latched")
    `FFR_ASSERT_NEXT(a_pos_hold, !in_xfer, $stable(r_pos) && $stable(r_held), "frame state moved without transfer")

endmodule

@@ verif/fixed_frame_receiver_tb.sv @@
// Self-checking testbench for fixed_frame_receiver: framed byte stream in, status and words out.
// Depends on ffr_pkg and the fixed_frame_receiver RTL.
// A scoreboard class predicts each result; plain tasks drive bytes with random gaps, an always block random stalls.

module fixed_frame_receiver_tb
    import ffr_pkg::*;
();

    // Scoreboard: tracks the frame state and holds the results still owed by the block.
    class frame_scoreboard;
        logic [3:0]  frame_pos;
        logic [7:0]  payload [PAY_LEN];
        logic [15:0] held [WORD_COUNT];
        t_result     pending [$];
        int unsigned failures;
        int unsigned checked;
        int unsigned good_frames;
        int unsigned framing_errors;
        string       word_name [WORD_COUNT] = '{"pwm_left", "pwm_right", "enc_left",
                                                 "enc_right", "spd_left", "spd_right"};

        function new();
            frame_pos = POS_HDR0;
            foreach (payload[i]) payload[i] = 8'h00;
            foreach (held[i]) held[i] = 16'h0000;
            failures = 0;
            checked = 0;
            good_frames = 0;
            framing_errors = 0;
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10) begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
        endfunction

        // Advance the frame state on one accepted byte and queue the result it causes.
        function void note_byte(logic [7:0] rx);
            logic    bad;
            t_result want;
            bad = 1'b0;
            case (frame_pos)
                POS_HDR0: bad = (rx != HDR0);
                POS_HDR1: bad = (rx != HDR1);
                POS_TRL0: bad = (rx != TRL0);
                POS_TRL1: bad = (rx != TRL1);
                default:  payload[frame_pos - POS_PAY_FIRST] = rx;
            endcase
            if (bad) begin
                want.status = ST_ERR;
                frame_pos = POS_HDR0;
                foreach (payload[i]) payload[i] = 8'h00;
                framing_errors++;
            end else if (frame_pos == POS_TRL1) begin
                want.status = ST_GOOD;
                frame_pos = POS_HDR0;
                foreach (held[k]) held[k] = {payload[2*k], payload[2*k+1]};
                good_frames++;
            end else begin
                want.status = ST_BUSY;
                frame_pos = frame_pos + 4'd1;
            end
            foreach (held[k]) want.words[k] = held[k];
            pending.push_back(want);
        endfunction

        // Compare one result transfer with the oldest expectation, field by field.
        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                flag($sformatf("result with nothing expected (status %0d)", got.status));
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.status !== want.status) begin
                flag($sformatf("status: expected %0d, got %0d", want.status, got.status));
            end
            for (int k = 0; k < WORD_COUNT; k++) begin
                if (got.words[k] !== want.words[k]) begin
                    flag($sformatf("word %s: expected %h, got %h",
                                   word_name[k], want.words[k], got.words[k]));
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_rx_data;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_frame_status;
    logic [15:0] o_word_pwm_left;
    logic [15:0] o_word_pwm_right;
    logic [15:0] o_word_enc_left;
    logic [15:0] o_word_enc_right;
    logic [15:0] o_word_spd_left;
    logic [15:0] o_word_spd_right;

    frame_scoreboard sb = new();

    // Burst phases: when set, the side draws no wait at all.
    bit          fast_source;
    bit          fast_sink;
    int unsigned bytes_sent;
    int unsigned stall_left;

    fixed_frame_receiver dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_data        (i_rx_data),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frame_status   (o_frame_status),
        .o_word_pwm_left  (o_word_pwm_left),
        .o_word_pwm_right (o_word_pwm_right),
        .o_word_enc_left  (o_word_enc_left),
        .o_word_enc_right (o_word_enc_right),
        .o_word_spd_left  (o_word_spd_left),
        .o_word_spd_right (o_word_spd_right)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: after each transfer, draw how many edges to hold stall before the next one.
    // The stall runs independently of o_valid, so it also lands on idle output cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (o_valid && !i_stall) begin
            stall_left = fast_sink ? 0 : $urandom_range(0, 17);
            i_stall <= (stall_left != 0);
        end else if (stall_left > 1) begin
            stall_left = stall_left - 1;
        end else begin
            stall_left = 0;
            i_stall <= 1'b0;
        end
    end

    // Monitor: sample the result transfer at the edge and hand it to the scoreboard.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.status   = t_status'(o_frame_status);
            got.words[0] = o_word_pwm_left;
            got.words[1] = o_word_pwm_right;
            got.words[2] = o_word_enc_left;
            got.words[3] = o_word_enc_right;
            got.words[4] = o_word_spd_left;
            got.words[5] = o_word_spd_right;
            sb.check_result(got);
        end
    end

    // Send one byte: idle for a random gap with junk on the data lines, then hold the byte
    // until it transfers. Valid is left high so a gapless next byte follows back to back.
    task automatic send_byte(input logic [7:0] rx);
        int unsigned gap;
        gap = fast_source ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_valid   <= 1'b0;
            i_rx_data <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_data <= rx;
        do @(posedge i_clk); while (o_stall);
        sb.note_byte(rx);
        bytes_sent++;
    endtask

    // Send a whole frame. A nonnegative cut_pos corrupts that byte with flip_mask;
    // the frame then stops there unless finish_rest asks for the remaining bytes.
    task automatic send_frame(input logic [7:0] pay [PAY_LEN], input int cut_pos,
                              input logic [7:0] flip_mask, input bit finish_rest);
        logic [7:0] frame [16];
        frame[POS_HDR0] = HDR0;
        frame[POS_HDR1] = HDR1;
        frame[POS_TRL0] = TRL0;
        frame[POS_TRL1] = TRL1;
        for (int i = 0; i < PAY_LEN; i++) frame[POS_PAY_FIRST + i] = pay[i];
        for (int p = 0; p < 16; p++) begin
            if (p == cut_pos) begin
                send_byte(frame[p] ^ flip_mask);
                if (!finish_rest) return;
            end else begin
                send_byte(frame[p]);
            end
        end
    endtask

    // Drop valid and wait until every owed result has transferred.
    task automatic drain();
        i_valid   <= 1'b0;
        i_rx_data <= 8'($urandom_range(0, 255));
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0]  pay [PAY_LEN];
        int unsigned pick;
        int unsigned sel;
        bit          paused;
        paused      = 1'b0;
        bytes_sent  = 0;
        fast_source = 1'b0;
        fast_sink   = 1'b0;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_rx_data <= 8'h00;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one good frame with extreme and alternating payload bytes,
        // a bad first header byte, and a 0x7F where the second header byte belongs
        // (the offending 0x7F must not restart a frame).
        pay = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE,
                8'h55, 8'hAA, 8'hFF, 8'h00, 8'h0F, 8'hF0};
        send_frame(pay, -1, 8'h00, 1'b0);
        send_byte(8'h7E);
        send_byte(HDR0);
        send_byte(HDR0);
        drain();

        // Random: mostly clean frames with random payload, some with a corrupted
        // header or trailer byte (truncated or continued), and some loose noise.
        while (bytes_sent < 1550) begin
            fast_source = ($urandom_range(0, 4) == 0);
            fast_sink   = ($urandom_range(0, 4) == 0);
            foreach (pay[i]) pay[i] = 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                send_frame(pay, -1, 8'h00, 1'b0);
            end else if (pick < 9) begin
                sel = $urandom_range(0, 3);
                send_frame(pay, int'((sel < 2) ? sel : sel + 12),
                           8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    case ($urandom_range(0, 3))
                        0:       send_byte(HDR0);
                        1:       send_byte(HDR1);
                        2:       send_byte(TRL1);
                        default: send_byte(8'($urandom_range(0, 255)));
                    endcase
                end
            end
            // Hold off once mid-run until the block has returned everything.
            if (!paused && bytes_sent >= 800) begin
                drain();
                paused = 1'b1;
            end
        end

        fast_sink = 1'b0;
        drain();
        repeat (8) @(posedge i_clk);

        $display("Covered %0d byte transfers and %0d checked results.", bytes_sent, sb.checked);
        $display("Frames: %0d good, %0d framing errors; %0d mismatches, %0d results left over.",
                 sb.good_frames, sb.framing_errors, sb.failures, sb.pending.size());
        if (sb.failures == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

endmodule
